[rtl/plo_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plo_pkg: shared types and constants of the price level order queue
// Field widths, operation and status codes, and parameter defaults.
// ----------------------------------------------------------------------------
package plo_pkg;

	// parameter defaults
	localparam int SLOTS_DEF     = 1024;
	localparam int SIZE_BITS_DEF = 32;

	// fixed field widths
	localparam int SLOT_FIELD_W = 10;
	localparam int SIZE_FIELD_W = 32;
	localparam int VOL_W        = 42;
	localparam int CNT_W        = 11;

	// operation codes
	typedef enum logic {
		OP_ADD    = 1'b0,
		OP_REMOVE = 1'b1
	} plo_op_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_ABSENT  = 2'd1,
		ST_REFUSED = 2'd2
	} plo_status_t;

endpackage

[rtl/plo_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plo_if: channel interfaces of the price level order queue
// Command channel (add or remove an order) and result channel, both
// valid/ready; a transaction moves when valid and ready are high at a clock edge.
// ----------------------------------------------------------------------------
interface plo_cmd_if;
	import plo_pkg::*;

	logic                    valid;
	logic                    ready;
	plo_op_t                 opcode;
	logic [SLOT_FIELD_W-1:0] order_slot;
	logic [SIZE_FIELD_W-1:0] order_size;

	modport source (output valid, output opcode, output order_slot, output order_size,
		input ready);
	modport sink (input valid, input opcode, input order_slot, input order_size,
		output ready);
endinterface

interface plo_res_if;
	import plo_pkg::*;

	logic                    valid;
	logic                    ready;
	plo_status_t             status;
	logic [VOL_W-1:0]        level_volume;
	logic [CNT_W-1:0]        order_count;
	logic                    level_empty;
	logic [SLOT_FIELD_W-1:0] front_slot;
	logic [SLOT_FIELD_W-1:0] back_slot;

	modport source (output valid, output status, output level_volume, output order_count,
		output level_empty, output front_slot, output back_slot, input ready);
	modport sink (input valid, input status, input level_volume, input order_count,
		input level_empty, input front_slot, input back_slot, output ready);
endinterface

[rtl/plo_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plo_ram: simple dual port memory with registered read
// One write and one read port; a read of the address written at the same
// edge returns the new data.
// ----------------------------------------------------------------------------
module plo_ram #(
	parameter int DEPTH = plo_pkg::SLOTS_DEF,
	parameter int WIDTH = plo_pkg::SLOT_FIELD_W,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, write-first on an address match
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= (we && (waddr == raddr)) ? wdata : mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/plo_clear.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plo_clear: membership store clearing sweep
// After reset walks every slot address once, one a cycle, and reports busy
// until the last slot has been cleared.
// ----------------------------------------------------------------------------
module plo_clear #(
	parameter int SLOTS = plo_pkg::SLOTS_DEF,
	localparam int AW   = $clog2(SLOTS)
) (
	input  logic          clk,
	input  logic          arst_n,
	output logic          busy,
	output logic [AW-1:0] addr
);

	logic          busy_q;
	logic [AW-1:0] addr_q;

	// sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			addr_q <= '0;
		end else if (busy_q) begin
			if (addr_q == AW'(SLOTS - 1)) begin
				busy_q <= 1'b0;
			end else begin
				addr_q <= addr_q + AW'(1);
			end
		end
	end

	assign busy = busy_q;
	assign addr = addr_q;

endmodule

[rtl/price_level_order_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// price_level_order_queue: one order book price level as a time-priority queue
// Orders are slots linked in next and previous link memories; adds append
// at the tail, removes unlink from head, tail or middle.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one transaction per operation: opcode (add or remove), the
//   order slot and, for an add, the order size. res returns one transaction
//   per command: status, total volume, order count, empty flag, head and tail.
//   Timing: the accepting edge captures the command and the memory read
//   data in the read stage; the edge that executes it then performs the
//   update and loads the result into the output register.
//   Throughput: one command per cycle while res is taken; each command
//   reads each memory once in the read stage and writes each at most once
//   in the update stage; writes forward to same-slot reads at the same edge.
//   Reset: the queue comes up empty; cmd.ready then stays low while the
//   membership memory is swept clear.
//   Stall: when res is not taken the result stays in the output register,
//   one more command can wait in the read stage, then cmd.ready falls.
// ----------------------------------------------------------------------------
module price_level_order_queue #(
	parameter int SLOTS     = plo_pkg::SLOTS_DEF,
	parameter int SIZE_BITS = plo_pkg::SIZE_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	plo_cmd_if.sink   cmd,
	plo_res_if.source res
);
	import plo_pkg::*;

	localparam int SLOT_W = $clog2(SLOTS);
	// internal count holds up to SLOTS orders, reported on CNT_W bits
	localparam int CQ_W   = (SLOT_W + 1 > CNT_W) ? SLOT_W + 1 : CNT_W;

	// clearing sweep
	logic              clr_busy;
	logic [SLOT_W-1:0] clr_addr;

	// handshake
	logic accept;
	logic exec;
	logic out_free;

	// read stage
	logic                 valid_s1;
	plo_op_t              op_s1;
	logic [SLOT_W-1:0]    idx_s1;
	logic [SIZE_BITS-1:0] size_s1;
	logic                 in_range_s1;
	logic [SLOT_W-1:0]    in_idx;

	// memory read data
	logic                 prs_rd;
	logic [SIZE_BITS-1:0] sz_rd;
	logic [SLOT_W-1:0]    nx_rd;
	logic [SLOT_W-1:0]    pv_rd;

	// queue state
	logic [SLOT_W-1:0] head_q, tail_q;
	logic              nonempty_q;
	logic [VOL_W-1:0]  vol_q;
	logic [CQ_W-1:0]   cnt_q;

	// update decisions
	plo_status_t       status_d;
	logic [SLOT_W-1:0] head_d, tail_d;
	logic              nonempty_d;
	logic [VOL_W-1:0]  vol_d;
	logic [CQ_W-1:0]   cnt_d;
	logic              pres_wx, pres_dx, size_wx, next_wx, prev_wx;
	logic [SLOT_W-1:0] next_wa, next_wd, prev_wa, prev_wd;

	// membership write port, shared with the sweep
	logic              pres_we;
	logic [SLOT_W-1:0] pres_wa;
	logic              pres_wd;

	// output register
	logic                    res_valid_q;
	plo_status_t             status_q;
	logic [VOL_W-1:0]        vol_out_q;
	logic [CNT_W-1:0]        cnt_out_q;
	logic                    empty_out_q;
	logic [SLOT_FIELD_W-1:0] front_q, back_q;

	plo_clear #(.SLOTS(SLOTS)) u_clear (
		.clk   (clk),
		.arst_n(arst_n),
		.busy  (clr_busy),
		.addr  (clr_addr)
	);

	// handshake control
	assign out_free  = !res_valid_q || res.ready;
	assign exec      = valid_s1 && out_free;
	assign cmd.ready = !clr_busy && (!valid_s1 || exec);
	assign accept    = cmd.valid && cmd.ready;
	assign in_idx    = SLOT_W'(cmd.order_slot);

	// read stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (exec) begin
			valid_s1 <= 1'b0;
		end
	end

	// read stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1       <= cmd.opcode;
			idx_s1      <= in_idx;
			size_s1     <= SIZE_BITS'(cmd.order_size);
			in_range_s1 <= (32'(cmd.order_slot) < 32'(SLOTS));
		end
	end

	// slot memories
	assign pres_we = clr_busy || (exec && pres_wx);
	assign pres_wa = clr_busy ? clr_addr : idx_s1;
	assign pres_wd = clr_busy ? 1'b0 : pres_dx;

	plo_ram #(.DEPTH(SLOTS), .WIDTH(1)) u_present (
		.clk  (clk),
		.we   (pres_we),
		.waddr(pres_wa),
		.wdata(pres_wd),
		.re   (accept),
		.raddr(in_idx),
		.rdata(prs_rd)
	);

	plo_ram #(.DEPTH(SLOTS), .WIDTH(SIZE_BITS)) u_size (
		.clk  (clk),
		.we   (exec && size_wx),
		.waddr(idx_s1),
		.wdata(size_s1),
		.re   (accept),
		.raddr(in_idx),
		.rdata(sz_rd)
	);

	plo_ram #(.DEPTH(SLOTS), .WIDTH(SLOT_W)) u_next (
		.clk  (clk),
		.we   (exec && next_wx),
		.waddr(next_wa),
		.wdata(next_wd),
		.re   (accept),
		.raddr(in_idx),
		.rdata(nx_rd)
	);

	plo_ram #(.DEPTH(SLOTS), .WIDTH(SLOT_W)) u_prev (
		.clk  (clk),
		.we   (exec && prev_wx),
		.waddr(prev_wa),
		.wdata(prev_wd),
		.re   (accept),
		.raddr(in_idx),
		.rdata(pv_rd)
	);

	// add and remove decisions
	always_comb begin
		status_d   = ST_DONE;
		head_d     = head_q;
		tail_d     = tail_q;
		nonempty_d = nonempty_q;
		vol_d      = vol_q;
		cnt_d      = cnt_q;
		pres_wx    = 1'b0;
		pres_dx    = 1'b0;
		size_wx    = 1'b0;
		next_wx    = 1'b0;
		next_wa    = tail_q;
		next_wd    = idx_s1;
		prev_wx    = 1'b0;
		prev_wa    = idx_s1;
		prev_wd    = tail_q;
		if (op_s1 == OP_ADD) begin
			if (!in_range_s1 || prs_rd) begin
				status_d = ST_REFUSED;
			end else begin
				pres_wx    = 1'b1;
				pres_dx    = 1'b1;
				size_wx    = 1'b1;
				vol_d      = vol_q + VOL_W'(size_s1);
				cnt_d      = cnt_q + CQ_W'(1);
				tail_d     = idx_s1;
				nonempty_d = 1'b1;
				if (!nonempty_q) begin
					head_d = idx_s1;
				end else begin
					// link behind the current tail
					next_wx = 1'b1;
					prev_wx = 1'b1;
				end
			end
		end else begin
			if (!in_range_s1 || !prs_rd || !nonempty_q) begin
				status_d = ST_ABSENT;
			end else begin
				pres_wx = 1'b1;
				vol_d   = vol_q - VOL_W'(sz_rd);
				if (cnt_q != '0) begin
					cnt_d = cnt_q - CQ_W'(1);
				end
				if ((head_q == idx_s1) && (tail_q == idx_s1)) begin
					nonempty_d = 1'b0;
					head_d     = '0;
					tail_d     = '0;
				end else if (head_q == idx_s1) begin
					head_d = nx_rd;
				end else if (tail_q == idx_s1) begin
					tail_d = pv_rd;
				end else begin
					// unlink from the middle
					next_wx = 1'b1;
					next_wa = pv_rd;
					next_wd = nx_rd;
					prev_wx = 1'b1;
					prev_wa = nx_rd;
					prev_wd = pv_rd;
				end
			end
		end
	end

	// queue state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			tail_q     <= '0;
			nonempty_q <= 1'b0;
			vol_q      <= '0;
			cnt_q      <= '0;
		end else if (exec) begin
			head_q     <= head_d;
			tail_q     <= tail_d;
			nonempty_q <= nonempty_d;
			vol_q      <= vol_d;
			cnt_q      <= cnt_d;
		end
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (exec) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (exec) begin
			status_q    <= status_d;
			vol_out_q   <= vol_d;
			cnt_out_q   <= CNT_W'(cnt_d);
			empty_out_q <= !nonempty_d;
			front_q     <= nonempty_d ? SLOT_FIELD_W'(head_d) : '0;
			back_q      <= nonempty_d ? SLOT_FIELD_W'(tail_d) : '0;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.status       = status_q;
	assign res.level_volume = vol_out_q;
	assign res.order_count  = cnt_out_q;
	assign res.level_empty  = empty_out_q;
	assign res.front_slot   = front_q;
	assign res.back_slot    = back_q;

endmodule

[rtl/plo_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plo_checker: result channel checks of the price level order queue
// Watches the result port only; bound to the top level below.
// ----------------------------------------------------------------------------
module plo_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              res_valid,
	input logic                              res_ready,
	input plo_pkg::plo_status_t              status,
	input logic [plo_pkg::VOL_W-1:0]         level_volume,
	input logic [plo_pkg::CNT_W-1:0]         order_count,
	input logic                              level_empty,
	input logic [plo_pkg::SLOT_FIELD_W-1:0]  front_slot,
	input logic [plo_pkg::SLOT_FIELD_W-1:0]  back_slot
);
	import plo_pkg::*;

	// empty flag agrees with the order count
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (level_empty == (order_count == '0)))
	else $error("level_empty disagrees with order_count");

	// an empty level reports zero head and tail
	a_empty_slots: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && level_empty) |-> ((front_slot == '0) && (back_slot == '0)))
	else $error("empty level with nonzero head or tail");

	// a refused or ignored command leaves count and volume as the previous result
	a_noop_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_ready) ##1 (res_valid && (status != ST_DONE)) |->
		((order_count == $past(order_count)) && (level_volume == $past(level_volume))))
	else $error("rejected command changed the level");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(status)
		&& $stable(level_volume) && $stable(order_count)))
	else $error("stalled result changed");

endmodule

bind price_level_order_queue plo_checker u_plo_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.status      (res.status),
	.level_volume(res.level_volume),
	.order_count (res.order_count),
	.level_empty (res.level_empty),
	.front_slot  (res.front_slot),
	.back_slot   (res.back_slot)
);
